// ----- sv/status_led_prompt_sequencer_top_assert.svh -----
// Assertion macros for the status LED prompt sequencer checker.
// Depends on nothing; included by the checker file.
`ifndef STATUS_LED_PROMPT_SEQUENCER_TOP_ASSERT_SVH
`define STATUS_LED_PROMPT_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLPS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slps assertion failed");

// Next-cycle implication, disabled during reset.
`define SLPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slps assertion failed");

`endif

// ----- sv/slps_pkg.sv -----
// Shared constants, command/status types and helpers for the status LED sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package slps_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int STATUS_W    = 3;
   localparam int LED_W       = 2;
   localparam int QCNT_W      = 4;
   localparam int INTERVAL_W  = 16;
   localparam int HOLD_W      = 8;
   localparam int STEP_W      = 8;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [STATUS_W-1:0] ST_FATAL   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BOOTING = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UPGRADE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_WARNING = 3'd4;
   localparam logic [STATUS_W-1:0] ST_INITING = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NORMAL  = 3'd6;
   localparam logic [STATUS_W-1:0] ST_NONE    = 3'd7;

   localparam logic [LED_W-1:0] LED_OFF    = 2'd0;
   localparam logic [LED_W-1:0] LED_RED    = 2'd1;
   localparam logic [LED_W-1:0] LED_GREEN  = 2'd2;
   localparam logic [LED_W-1:0] LED_YELLOW = 2'd3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_REQ  = 1'b1;

   localparam logic REG_TICK_INTERVAL = 1'b0;
   localparam logic REG_HOLD_STEPS    = 1'b1;

   localparam logic [INTERVAL_W-1:0] TICK_INTERVAL_RST = 16'd200;
   localparam logic [HOLD_W-1:0]     HOLD_STEPS_RST    = 8'd12;

   typedef struct packed {
      logic capture;
      logic read;
      logic exec;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   // Queue index addition modulo the depth; both operands below the depth.
   function automatic logic [QADDR_W-1:0] wrap_add(logic [QADDR_W-1:0] a,
                                                   logic [QADDR_W-1:0] b);
      logic [QADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (QADDR_W+1)'(QUEUE_DEPTH)) begin
         s = s - (QADDR_W+1)'(QUEUE_DEPTH);
      end
      return s[QADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- sv/slps_csr.sv -----
// Configuration registers (tick interval, hold steps) behind the APB-style port.
// Depends on slps_pkg.
`default_nettype none

module slps_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [slps_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [slps_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [slps_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                      csr_pready,
   output logic      [slps_pkg::INTERVAL_W-1:0]      tick_interval,
   output logic      [slps_pkg::HOLD_W-1:0]          hold_steps
);

   logic [slps_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [slps_pkg::HOLD_W-1:0]     hold_ff, hold_in;
   logic                            wr_en;
   logic                            reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      interval_in = interval_ff;
      hold_in     = hold_ff;
      if (wr_en) begin
         case (reg_sel)
            slps_pkg::REG_TICK_INTERVAL: interval_in = csr_pwdata[slps_pkg::INTERVAL_W-1:0];
            slps_pkg::REG_HOLD_STEPS:    hold_in     = csr_pwdata[slps_pkg::HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= slps_pkg::TICK_INTERVAL_RST;
         hold_ff     <= slps_pkg::HOLD_STEPS_RST;
      end else begin
         interval_ff <= interval_in;
         hold_ff     <= hold_in;
      end
   end

   always_comb begin
      case (reg_sel)
         slps_pkg::REG_TICK_INTERVAL:
            csr_prdata = slps_pkg::CSR_DATA_W'(interval_ff);
         slps_pkg::REG_HOLD_STEPS:
            csr_prdata = slps_pkg::CSR_DATA_W'(hold_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   assign tick_interval = interval_ff;
   assign hold_steps    = hold_ff;

endmodule

`default_nettype wire

// ----- sv/slps_ctrl.sv -----
// Sequencing state machine: capture, queue read, update, result load.
// Depends on slps_pkg for the command and status structs.
`default_nettype none

module slps_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire slps_pkg::stat_type stat,
   output slps_pkg::cmd_type       cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE) & ~reset;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the result register can take the transaction
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/slps_datapath.sv -----
// Status queue memory, step and tick counters, LED state and the result register.
// Depends on slps_pkg; driven by commands from slps_ctrl.
`default_nettype none

module slps_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire slps_pkg::cmd_type                   cmd,
   output slps_pkg::stat_type                       stat,
   input  wire logic                                in_op,
   input  wire logic [slps_pkg::STATUS_W-1:0]       in_status,
   input  wire logic [slps_pkg::INTERVAL_W-1:0]     tick_interval,
   input  wire logic [slps_pkg::HOLD_W-1:0]         hold_steps,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tvalid,
   output logic      [slps_pkg::LED_W-1:0]          out_led_color,
   output logic      [slps_pkg::STATUS_W-1:0]       out_shown_status,
   output logic      [slps_pkg::QCNT_W-1:0]         out_queue_count
);

   localparam int QA = slps_pkg::QADDR_W;
   localparam int FW = slps_pkg::FILL_W;

   // captured item
   logic                          op_ff;
   logic [slps_pkg::STATUS_W-1:0] st_ff;

   logic [slps_pkg::STATUS_W-1:0] queue_mem_ff [slps_pkg::QUEUE_DEPTH];
   logic [slps_pkg::STATUS_W-1:0] rd_data_ff;

   logic [QA-1:0]                   head_ff, head_in;
   logic [FW-1:0]                   fill_ff, fill_in;
   logic [slps_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [slps_pkg::INTERVAL_W-1:0] cnt_ff, cnt_in;
   logic [slps_pkg::LED_W-1:0]      led_ff, led_in;
   logic [slps_pkg::STATUS_W-1:0]   last_ff, last_in;

   logic                            rsp_valid_ff;
   logic [slps_pkg::LED_W-1:0]      rsp_led_ff;
   logic [slps_pkg::STATUS_W-1:0]   rsp_shown_ff;
   logic [slps_pkg::QCNT_W-1:0]     rsp_qcnt_ff;

   logic                            fire;
   logic                            drop;
   logic [FW-1:0]                   fill_m1;
   logic [QA-1:0]                   head_next;
   logic [QA-1:0]                   rd_addr;
   logic [QA-1:0]                   wr_addr;
   logic                            wr_en;
   logic [QA-1:0]                   head_b;
   logic [FW-1:0]                   fill_b;
   logic [slps_pkg::STEP_W-1:0]     step_b;
   logic [slps_pkg::LED_W-1:0]      blink_led;

   assign fire      = (cnt_ff == '0);
   assign drop      = (fill_ff >= FW'(2)) && (step_ff >= hold_steps);
   assign fill_m1   = fill_ff - FW'(1);
   assign head_next = slps_pkg::wrap_add(head_ff, QA'(1));
   assign wr_addr   = slps_pkg::wrap_add(head_ff, fill_ff[QA-1:0]);

   // tick step reads the head after a possible drop; a request reads the newest entry
   always_comb begin
      if (op_ff == slps_pkg::OP_TICK) begin
         rd_addr = (fire && drop) ? head_next : head_ff;
      end else begin
         rd_addr = slps_pkg::wrap_add(head_ff, fill_m1[QA-1:0]);
      end
   end

   always_comb begin
      head_b = drop ? head_next : head_ff;
      fill_b = drop ? fill_m1 : fill_ff;
      step_b = drop ? '0 : step_ff;
   end

   always_comb begin
      case (rd_data_ff)
         slps_pkg::ST_ERROR:   blink_led = step_b[0] ? slps_pkg::LED_RED   : slps_pkg::LED_OFF;
         slps_pkg::ST_WARNING: blink_led = step_b[1] ? slps_pkg::LED_RED   : slps_pkg::LED_OFF;
         slps_pkg::ST_INITING: blink_led = step_b[0] ? slps_pkg::LED_GREEN : slps_pkg::LED_OFF;
         slps_pkg::ST_NORMAL:  blink_led = step_b[1] ? slps_pkg::LED_GREEN : slps_pkg::LED_OFF;
         default:              blink_led = slps_pkg::LED_RED;
      endcase
   end

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      step_in = step_ff;
      cnt_in  = cnt_ff;
      led_in  = led_ff;
      last_in = last_ff;
      wr_en   = 1'b0;
      if (op_ff == slps_pkg::OP_TICK) begin
         if (fire) begin
            cnt_in  = (tick_interval == '0) ? '0
                                            : tick_interval - slps_pkg::INTERVAL_W'(1);
            step_in = step_b + slps_pkg::STEP_W'(1);
            if (fill_b == '0) begin
               head_in = '0;
               fill_in = '0;
               led_in  = slps_pkg::LED_RED;
               last_in = slps_pkg::ST_NONE;
            end else begin
               head_in = head_b;
               fill_in = fill_b;
               led_in  = blink_led;
               last_in = rd_data_ff;
            end
         end else begin
            cnt_in = cnt_ff - slps_pkg::INTERVAL_W'(1);
         end
      end else begin
         case (st_ff)
            slps_pkg::ST_FATAL, slps_pkg::ST_BOOTING, slps_pkg::ST_UPGRADE: begin
               head_in = '0;
               fill_in = '0;
               last_in = st_ff;
               step_in = step_ff + slps_pkg::STEP_W'(1);
               case (st_ff)
                  slps_pkg::ST_FATAL:   led_in = slps_pkg::LED_RED;
                  slps_pkg::ST_BOOTING: led_in = slps_pkg::LED_GREEN;
                  default:              led_in = slps_pkg::LED_YELLOW;
               endcase
            end
            slps_pkg::ST_ERROR, slps_pkg::ST_WARNING,
            slps_pkg::ST_INITING, slps_pkg::ST_NORMAL: begin
               // drop when full or a repeat of the newest entry
               if (fill_ff < FW'(slps_pkg::QUEUE_DEPTH) &&
                   !(fill_ff != '0 && rd_data_ff == st_ff)) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= in_op;
         st_ff <= in_status;
      end
      if (cmd.read) begin
         rd_data_ff <= queue_mem_ff[rd_addr];
      end
      if (cmd.exec && wr_en) begin
         queue_mem_ff[wr_addr] <= st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         step_ff <= '0;
         cnt_ff  <= '0;
         led_ff  <= slps_pkg::LED_OFF;
         last_ff <= slps_pkg::ST_NONE;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
         led_ff  <= led_in;
         last_ff <= last_in;
      end
   end

   assign stat.out_free = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_led_ff   <= led_ff;
         rsp_shown_ff <= last_ff;
         rsp_qcnt_ff  <= slps_pkg::QCNT_W'(fill_ff);
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign out_led_color    = rsp_led_ff;
   assign out_shown_status = rsp_shown_ff;
   assign out_queue_count  = rsp_qcnt_ff;

endmodule

`default_nettype wire

// ----- sv/status_led_prompt_sequencer_top.sv -----
// Status LED prompt sequencer: one result per tick or status request.
//
// Input stream (req_): req_tuser is the item kind (0 millisecond tick,
// 1 status request), req_tdata[2:0] the status code (ignored on a tick).
// Result stream (rsp_): LED color, status last shown and queued count.
// Configuration (csr_): tick interval at byte 0, hold steps at byte 4;
// pready is always high, writes land on the access cycle.
//
// Each item passes through capture, registered queue memory read,
// state update and result load. rsp_tvalid rises when the result is loaded,
// and req_tready returns at the same time. The queue memory has one port,
// one read per item; a new item is accepted only once the last is loaded.
// Reset empties the queue, turns the LED off, shows "none" and primes the
// tick counter so the first tick fires a step; queue contents are not
// cleared and need no clearing pass. A stalled receiver holds the result
// in the output register; the next item is still accepted and finishes
// up to the load, where it waits for the register to drain.
// Depends on slps_pkg, slps_csr, slps_ctrl and slps_datapath.
`default_nettype none

module status_led_prompt_sequencer_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [7:0]                          req_tdata,  // [2:0] status
   input  wire logic                                req_tuser,  // [0] op
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [1:0] led_color, [4:2] shown_status, [8:5] queue_count, rest zero
   output logic      [15:0]                         rsp_tdata,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [slps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [slps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [slps_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

   slps_pkg::cmd_type                cmd;
   slps_pkg::stat_type               stat;
   logic [slps_pkg::INTERVAL_W-1:0]  tick_interval;
   logic [slps_pkg::HOLD_W-1:0]      hold_steps;
   logic [slps_pkg::LED_W-1:0]       led_color;
   logic [slps_pkg::STATUS_W-1:0]    shown_status;
   logic [slps_pkg::QCNT_W-1:0]      queue_count;

   slps_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .tick_interval (tick_interval),
      .hold_steps    (hold_steps)
   );

   slps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   slps_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_op            (req_tuser),
      .in_status        (req_tdata[slps_pkg::STATUS_W-1:0]),
      .tick_interval    (tick_interval),
      .hold_steps       (hold_steps),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .out_led_color    (led_color),
      .out_shown_status (shown_status),
      .out_queue_count  (queue_count)
   );

   assign rsp_tdata = {7'b0, queue_count, shown_status, led_color};

endmodule

`default_nettype wire

// ----- sv/slps_checker.sv -----
// Port-level checker for the status LED sequencer, bound to the top level.
// Depends on slps_pkg and status_led_prompt_sequencer_top_assert.svh.
`default_nettype none

`include "status_led_prompt_sequencer_top_assert.svh"

module slps_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [15:0]                         rsp_tdata
);

   logic [slps_pkg::LED_W-1:0]    rsp_led;
   logic [slps_pkg::STATUS_W-1:0] rsp_shown;
   logic [slps_pkg::QCNT_W-1:0]   rsp_qcnt;
   logic                          rsp_stall;
   logic                          req_accept;
   logic                          qcnt_ok;
   logic                          led_yellow;
   logic                          shown_upgrade;
   logic                          shown_none;
   logic                          led_red_off;

   assign rsp_led       = rsp_tdata[1:0];
   assign rsp_shown     = rsp_tdata[4:2];
   assign rsp_qcnt      = rsp_tdata[8:5];
   assign rsp_stall     = rsp_tvalid & ~rsp_tready;
   assign req_accept    = req_tvalid & req_tready;
   assign qcnt_ok       = (rsp_qcnt <= slps_pkg::QCNT_W'(slps_pkg::QUEUE_DEPTH));
   assign led_yellow    = rsp_tvalid && (rsp_led == slps_pkg::LED_YELLOW);
   assign shown_upgrade = (rsp_shown == slps_pkg::ST_UPGRADE);
   assign shown_none    = rsp_tvalid && (rsp_shown == slps_pkg::ST_NONE);
   assign led_red_off   = (rsp_led == slps_pkg::LED_RED) || (rsp_led == slps_pkg::LED_OFF);

   // a stalled result transaction stays put
   `SLPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // one item in flight: no second acceptance right after one
   `SLPS_ASSERT_NEXT(a_one_item, clock, reset, req_accept, !req_tready)

   `SLPS_ASSERT_IMPLY(a_qcnt_range, clock, reset, rsp_tvalid, qcnt_ok)

   // yellow only comes from an upgrade request
   `SLPS_ASSERT_IMPLY(a_yellow_upgrade, clock, reset, led_yellow, shown_upgrade)

   // nothing shown: LED is off (after reset) or solid red (empty queue)
   `SLPS_ASSERT_IMPLY(a_none_red, clock, reset, shown_none, led_red_off)

endmodule

bind status_led_prompt_sequencer_top slps_checker u_slps_checker (.*);

`default_nettype wire
